FILE: design/apc_pkg.sv
package apc_pkg;

  // default number of low input bits taken into account
  localparam int APC_NUMBER_WIDTH = 16;
  // width of each divisor sum on the result channel
  localparam int APC_SUM_OUT_WIDTH = 18;
  // guard bits of an internal divisor sum over the number width
  localparam int APC_SUM_GUARD = 3;

  typedef struct packed {
    logic start;
    logic take;
  } apc_lane_ctl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } apc_lane_sts_t;

endpackage

FILE: design/apc_if.sv
interface apc_in_if
  import apc_pkg::*;
#(
  parameter int NUMBER_WIDTH = APC_NUMBER_WIDTH
);
  logic                    valid;
  logic                    ready;
  logic [NUMBER_WIDTH-1:0] first_number;
  logic [NUMBER_WIDTH-1:0] second_number;

  modport source (output valid, output first_number, output second_number, input ready);
  modport sink (input valid, input first_number, input second_number, output ready);
endinterface

interface apc_out_if
  import apc_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic [APC_SUM_OUT_WIDTH-1:0] first_divisor_sum;
  logic [APC_SUM_OUT_WIDTH-1:0] second_divisor_sum;
  logic                         amicable;

  modport source (output valid, output first_divisor_sum, output second_divisor_sum,
                  output amicable, input ready);
  modport sink (input valid, input first_divisor_sum, input second_divisor_sum,
                input amicable, output ready);
endinterface

FILE: design/amicable_pair_check_core.sv
// Amicable pair check: each input transfer carries two numbers; for each the
// block forms the aliquot sum (all divisors below the number) and returns both
// sums with a flag that is set when each sum equals the other number, so a
// perfect number paired with itself also sets the flag. Two lanes, one per
// number, run side by side; each lane walks trial divisors d = 2, 3, ... while
// d <= n/d and uses a bit-serial restoring divider followed by an accumulate
// step for each d; a number below 2 skips the divider with a zero sum.
// Results wait in an output register, so the next item is taken as soon as
// the lanes hand over their sums. Only the low NUMBER_WIDTH bits of each
// number count; the flag is decided on the full internal sums and each sum
// field carries the low 18 bits.
module amicable_pair_check_core
  import apc_pkg::*;
#(
  parameter int NUMBER_WIDTH = APC_NUMBER_WIDTH
) (
  input  logic          clk,
  input  logic          rst_n,
  apc_in_if.sink        in_if,
  apc_out_if.source     out_if
);

  localparam int SW = NUMBER_WIDTH + APC_SUM_GUARD;
  localparam int OW = APC_SUM_OUT_WIDTH;
  localparam int EW = (SW > OW) ? SW : OW;

  apc_lane_ctl_t lane_ctl;
  apc_lane_sts_t sts_a, sts_b;
  logic [SW-1:0] sum_a, sum_b;

  // operands kept for the pair compare at merge time
  logic [NUMBER_WIDTH-1:0] num_a_r, num_b_r;

  logic out_valid_r;
  logic [OW-1:0] out_sum_a_r, out_sum_b_r;
  logic out_amicable_r;

  logic in_xfer;
  logic merge;
  logic [EW-1:0] sum_a_ext, sum_b_ext;

  // input side: a new pair starts only when both lanes are free
  assign in_if.ready = sts_a.idle & sts_b.idle;
  assign in_xfer     = in_if.valid & in_if.ready;

  // merge once both lanes finished and the output register can take it
  assign merge = sts_a.done & sts_b.done & (~out_valid_r | out_if.ready);

  assign lane_ctl.start = in_xfer;
  assign lane_ctl.take  = merge;

  apc_lane #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_lane_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .number (in_if.first_number),
    .sts    (sts_a),
    .sum    (sum_a)
  );

  apc_lane #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_lane_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (lane_ctl),
    .number (in_if.second_number),
    .sts    (sts_b),
    .sum    (sum_b)
  );

  // sum fields carry the low bits of the full sums
  assign sum_a_ext = EW'(sum_a);
  assign sum_b_ext = EW'(sum_b);

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      num_a_r <= in_if.first_number;
      num_b_r <= in_if.second_number;
    end
  end

  // output register: holds a result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (merge) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
    if (merge) begin
      out_sum_a_r    <= sum_a_ext[OW-1:0];
      out_sum_b_r    <= sum_b_ext[OW-1:0];
      // pair test on the unmasked sums
      out_amicable_r <= (sum_a == SW'(num_b_r)) && (sum_b == SW'(num_a_r));
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.first_divisor_sum  = out_sum_a_r;
  assign out_if.second_divisor_sum = out_sum_b_r;
  assign out_if.amicable           = out_amicable_r;

endmodule

FILE: design/apc_lane.sv
module apc_lane
  import apc_pkg::*;
#(
  parameter int NUMBER_WIDTH = APC_NUMBER_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  apc_lane_ctl_t                         ctl,
  input  logic [NUMBER_WIDTH-1:0]               number,
  output apc_lane_sts_t                         sts,
  output logic [NUMBER_WIDTH+APC_SUM_GUARD-1:0] sum
);

  localparam int NW = NUMBER_WIDTH;
  localparam int SW = NUMBER_WIDTH + APC_SUM_GUARD;
  localparam int CW = $clog2(NUMBER_WIDTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [NW-1:0] d_r, d_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] total_r, total_nxt;

  // one restoring division step: remainder and quotient share the shift
  logic [NW:0] rem_shift;
  logic [NW:0] rem_sub;
  logic        fits;

  assign rem_shift = {rem_r, quo_r[NW-1]};
  assign rem_sub   = rem_shift - {1'b0, d_r};
  assign fits      = rem_shift >= {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    total_nxt = total_r;
    unique case (state_r)
      S_IDLE: begin
        if (ctl.start) begin
          n_nxt   = number;
          d_nxt   = NW'(2);
          rem_nxt = '0;
          quo_nxt = number;
          cnt_nxt = '0;
          if (number < NW'(2)) begin
            total_nxt = '0;
            state_nxt = S_DONE;
          end else begin
            total_nxt = SW'(1);
            state_nxt = S_DIV;
          end
        end
      end
      S_DIV: begin
        rem_nxt = fits ? rem_sub[NW-1:0] : rem_shift[NW-1:0];
        quo_nxt = {quo_r[NW-2:0], fits};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(NW - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        // d*d <= n holds exactly when d <= floor(n/d)
        if (d_r > quo_r) begin
          state_nxt = S_DONE;
        end else begin
          if (rem_r == '0) begin
            total_nxt = total_r + SW'(d_r) + ((quo_r != d_r) ? SW'(quo_r) : '0);
          end
          d_nxt     = d_r + NW'(1);
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DONE: begin
        if (ctl.take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    total_r <= total_nxt;
  end

  assign sts.idle = (state_r == S_IDLE);
  assign sts.done = (state_r == S_DONE);
  assign sum      = total_r;

endmodule

FILE: design/apc_check.sv
module apc_check
  import apc_pkg::*;
(
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [APC_SUM_OUT_WIDTH-1:0] first_divisor_sum,
  input logic [APC_SUM_OUT_WIDTH-1:0] second_divisor_sum,
  input logic                         amicable
);

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(first_divisor_sum)
      && $stable(second_divisor_sum) && $stable(amicable))
    else $error("result changed while stalled");

  // no result shows right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a taken pair keeps the lanes busy
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready right after a transfer");

  // handing a result to the output frees the lanes
  a_free_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("lanes not freed when result appeared");

endmodule

bind amicable_pair_check_core apc_check u_apc_check (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_if.valid),
  .in_ready           (in_if.ready),
  .out_valid          (out_if.valid),
  .out_ready          (out_if.ready),
  .first_divisor_sum  (out_if.first_divisor_sum),
  .second_divisor_sum (out_if.second_divisor_sum),
  .amicable           (out_if.amicable)
);
